// ----- rtl/qd_pkg.sv -----
// ----------------------------------------------------------------------------
// qd_pkg: shared types and constants of the 2x2 window reducer
// Pixel widths, lane count, register indexes and the stage structs.
// ----------------------------------------------------------------------------
package qd_pkg;

    localparam int FIELD_W    = 16;
    localparam int PIXEL_BITS = 16;
    localparam int LANES      = 4;

    // Sign-extended pixel, window sum with rounding bias, and its magnitude
    localparam int VAL_W = PIXEL_BITS + 1;
    localparam int SUM_W = PIXEL_BITS + 3;
    localparam int MAG_W = PIXEL_BITS + 2;
    localparam int CNT_W = 3;

    // Divide by three: floor(n / 3) = (n * RCP3) >> RCP_SH, exact for n < 2**MAG_W
    localparam int RCP_SH  = MAG_W + 1;
    localparam int RCP_ADJ = (RCP_SH % 2 == 1) ? 1 : 2;
    localparam int RCP_W   = RCP_SH;
    localparam logic [RCP_W-1:0] RCP3 =
        RCP_W'(((64'd1 << RCP_SH) + 64'(RCP_ADJ)) / 64'd3);
    localparam int PROD_W = MAG_W + RCP_W;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE_NEAREST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NODATA_ENABLE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_NODATA_VALUE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_PIXELS = CFG_IDX_W'(3);

    typedef struct packed {
        logic                  mode_nearest;
        logic                  nodata_enable;
        logic [PIXEL_BITS-1:0] nodata_value;
        logic                  signed_pixels;
    } t_cfg;

    typedef struct packed {
        logic                    counted;
        logic                    nodata;
        logic signed [VAL_W-1:0] value;
        logic [PIXEL_BITS-1:0]   raw;
    } t_lane;

    typedef struct packed {
        logic                    nearest;
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic [PIXEL_BITS-1:0]   pick;
        logic                    last;
    } t_merge;

endpackage

// ----- rtl/qd_ifs.sv -----
// ----------------------------------------------------------------------------
// qd_ifs: handshake channels of the 2x2 window reducer
// Window input, reduced pixel output and register write channel.
// ----------------------------------------------------------------------------
interface qd_in_if import qd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] top_left;
    logic [FIELD_W-1:0] top_right;
    logic [FIELD_W-1:0] bottom_left;
    logic [FIELD_W-1:0] bottom_right;
    logic               last_in_tile;

    modport source (output valid, top_left, top_right, bottom_left, bottom_right,
                    last_in_tile, input ready);
    modport sink   (input valid, top_left, top_right, bottom_left, bottom_right,
                    last_in_tile, output ready);
endinterface

interface qd_out_if import qd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] reduced_pixel;
    logic               tile_done;

    modport source (output valid, reduced_pixel, tile_done, input ready);
    modport sink   (input valid, reduced_pixel, tile_done, output ready);
endinterface

interface qd_cfg_if import qd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/qd_lane.sv -----
// ----------------------------------------------------------------------------
// qd_lane: per-pixel classification lane
// Flags no-data, decides whether the pixel counts, sign- or zero-extends it.
// ----------------------------------------------------------------------------
module qd_lane import qd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_cfg               i_cfg,
    input  logic [FIELD_W-1:0] i_pixel,
    output t_lane              o_lane
);

    logic [PIXEL_BITS-1:0] pix;
    logic                  is_nd;
    t_lane                 n_lane;
    t_lane                 r_lane;

    always_comb begin
        pix            = PIXEL_BITS'(i_pixel);
        is_nd          = (pix == i_cfg.nodata_value);
        n_lane.raw     = pix;
        n_lane.nodata  = is_nd;
        n_lane.counted = !i_cfg.nodata_enable || !is_nd;
        n_lane.value   = i_cfg.signed_pixels ? {pix[PIXEL_BITS-1], pix} : {1'b0, pix};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ----- rtl/qd_merge.sv -----
// ----------------------------------------------------------------------------
// qd_merge: lane merging stage
// Sums counted pixels with rounding bias, counts them, picks nearest pixel.
// ----------------------------------------------------------------------------
module qd_merge import qd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_cfg   i_cfg,
    input  t_lane  i_lane [LANES],
    input  logic   i_last,
    output t_merge o_merge
);

    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
    logic [PIXEL_BITS-1:0]   pick;
    t_merge                  n_merge;
    t_merge                  r_merge;

    always_comb begin
        sum = '0;
        cnt = '0;
        for (int i = 0; i < LANES; i++) begin
            if (i_lane[i].counted) begin
                sum = sum + SUM_W'(i_lane[i].value);
                cnt = cnt + CNT_W'(1);
            end
        end

        // first pixel that is not no-data wins; fall back to the last one
        pick = i_lane[LANES-1].raw;
        for (int i = LANES - 2; i >= 0; i--) begin
            if (!i_lane[i].nodata) begin
                pick = i_lane[i].raw;
            end
        end
        if (!i_cfg.nodata_enable) begin
            pick = i_lane[0].raw;
        end

        n_merge.nearest = i_cfg.mode_nearest;
        n_merge.count   = cnt;
        n_merge.sum     = sum + SUM_W'(cnt >> 1);
        n_merge.pick    = pick;
        n_merge.last    = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_merge <= n_merge;
        end
    end

    assign o_merge = r_merge;

endmodule

// ----- rtl/qd_div.sv -----
// ----------------------------------------------------------------------------
// qd_div: divide by the pixel count, truncating toward zero
// Two stages: magnitude and reciprocal multiply, then quotient select.
// ----------------------------------------------------------------------------
module qd_div import qd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en_mul,
    input  logic               i_en_out,
    input  t_cfg               i_cfg,
    input  t_merge             i_merge,
    output logic [FIELD_W-1:0] o_pixel,
    output logic               o_last
);

    logic                  neg;
    logic [MAG_W-1:0]      mag;
    logic [PROD_W-1:0]     prod;
    logic [MAG_W-1:0]      quo;
    logic [MAG_W-1:0]      signed_quo;
    logic [PIXEL_BITS-1:0] n_pixel;

    logic                  r_nearest;
    logic [CNT_W-1:0]      r_count;
    logic                  r_neg;
    logic [MAG_W-1:0]      r_mag;
    logic [MAG_W-1:0]      r_third;
    logic [PIXEL_BITS-1:0] r_pick;
    logic                  r_last_mul;
    logic [PIXEL_BITS-1:0] r_pixel;
    logic                  r_last;

    // Multiply stage: split sign and magnitude, take a third of the magnitude
    always_comb begin
        neg  = i_merge.sum[SUM_W-1];
        mag  = neg ? MAG_W'(-i_merge.sum) : MAG_W'(i_merge.sum);
        prod = PROD_W'(mag) * PROD_W'(RCP3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_nearest  <= i_merge.nearest;
            r_count    <= i_merge.count;
            r_neg      <= neg;
            r_mag      <= mag;
            r_third    <= prod[RCP_SH +: MAG_W];
            r_pick     <= i_merge.pick;
            r_last_mul <= i_merge.last;
        end
    end

    // Output stage: signed quotient by count, nearest pick or no-data value
    always_comb begin
        case (r_count)
            CNT_W'(1): quo = r_mag;
            CNT_W'(2): quo = r_mag >> 1;
            CNT_W'(3): quo = r_third;
            CNT_W'(4): quo = r_mag >> 2;
            default:   quo = '0;
        endcase
        signed_quo = r_neg ? -quo : quo;

        if (r_nearest) begin
            n_pixel = r_pick;
        end else if (r_count == '0) begin
            n_pixel = i_cfg.nodata_value;
        end else begin
            n_pixel = PIXEL_BITS'(signed_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_pixel <= n_pixel;
            r_last  <= r_last_mul;
        end
    end

    assign o_pixel = FIELD_W'(r_pixel);
    assign o_last  = r_last;

endmodule

// ----- rtl/quad_downsample_nodata_core.sv -----
// ----------------------------------------------------------------------------
// quad_downsample_nodata_core: 2x2 window reducer for image pyramids
// Averages or picks one pixel out of each 2x2 window, skipping no-data.
// ----------------------------------------------------------------------------
// One item is a 2x2 window; each gives exactly one reduced pixel, in order.
// The block takes one item per clock unless output back-pressure fills the
// pipeline. A lane stage classifies the four pixels side by side, a merge
// stage sums the counted pixels with half their count as rounding bias and
// picks the nearest valid pixel, a multiply stage divides the magnitude by
// three through a reciprocal, and an output register selects the quotient
// for the count (one, two, three or four) and restores the sign, so the
// division truncates toward zero. Every stage holds its own valid bit and
// moves on as soon as the stage after it has room, so input is still taken
// while a result waits at the output as long as an earlier stage is empty.
// Registers are written through the configuration channel, which is always
// ready; write them only while the pipeline is empty. An index beyond the
// last register is ignored. All configuration registers reset to zero.
// ----------------------------------------------------------------------------
module quad_downsample_nodata_core import qd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qd_in_if.sink       i_in,
    qd_out_if.source    o_out,
    qd_cfg_if.sink      i_cfg
);

    t_cfg   r_cfg;
    logic   r_v_lane;
    logic   r_v_merge;
    logic   r_v_mul;
    logic   r_v_out;
    logic   r_last_lane;

    logic   rdy_lane;
    logic   rdy_merge;
    logic   rdy_mul;
    logic   rdy_out;

    logic [FIELD_W-1:0] w_pix [LANES];
    t_lane              w_lane [LANES];
    t_merge             w_merge;

    // Register writes: always accept, drop unknown indexes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MODE_NEAREST:  r_cfg.mode_nearest  <= i_cfg.data[0];
                REG_NODATA_ENABLE: r_cfg.nodata_enable <= i_cfg.data[0];
                REG_NODATA_VALUE:  r_cfg.nodata_value  <= PIXEL_BITS'(i_cfg.data);
                REG_SIGNED_PIXELS: r_cfg.signed_pixels <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its content moves on
    assign rdy_out    = !r_v_out   || o_out.ready;
    assign rdy_mul    = !r_v_mul   || rdy_out;
    assign rdy_merge  = !r_v_merge || rdy_mul;
    assign rdy_lane   = !r_v_lane  || rdy_merge;
    assign i_in.ready = rdy_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_lane  <= 1'b0;
            r_v_merge <= 1'b0;
            r_v_mul   <= 1'b0;
            r_v_out   <= 1'b0;
        end else begin
            if (rdy_lane) begin
                r_v_lane <= i_in.valid;
            end
            if (rdy_merge) begin
                r_v_merge <= r_v_lane;
            end
            if (rdy_mul) begin
                r_v_mul <= r_v_merge;
            end
            if (rdy_out) begin
                r_v_out <= r_v_mul;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_lane) begin
            r_last_lane <= i_in.last_in_tile;
        end
    end

    // Scan order of the window: top-left, top-right, bottom-left, bottom-right
    assign w_pix[0] = i_in.top_left;
    assign w_pix[1] = i_in.top_right;
    assign w_pix[2] = i_in.bottom_left;
    assign w_pix[3] = i_in.bottom_right;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        qd_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (rdy_lane),
            .i_cfg   (r_cfg),
            .i_pixel (w_pix[g]),
            .o_lane  (w_lane[g])
        );
    end

    qd_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (rdy_merge),
        .i_cfg   (r_cfg),
        .i_lane  (w_lane),
        .i_last  (r_last_lane),
        .o_merge (w_merge)
    );

    qd_div u_div (
        .i_clk    (i_clk),
        .i_en_mul (rdy_mul),
        .i_en_out (rdy_out),
        .i_cfg    (r_cfg),
        .i_merge  (w_merge),
        .o_pixel  (o_out.reduced_pixel),
        .o_last   (o_out.tile_done)
    );

    assign o_out.valid = r_v_out;

endmodule

// ----- rtl/qd_chk.sv -----
// ----------------------------------------------------------------------------
// qd_chk: port-level checker for the 2x2 window reducer
// Tracks items in flight and checks output holding and pipeline bounds.
// ----------------------------------------------------------------------------
module qd_chk import qd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [FIELD_W-1:0] i_out_pixel,
    input logic               i_out_last
);

    logic       in_fire;
    logic       out_fire;
    logic [2:0] r_inflight;

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(in_fire) - 3'(out_fire);
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pixel)
                                         && $stable(i_out_last))
        else $error("stalled result changed");

    // No result without an item behind it
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != 3'd0)
        else $error("result with no item in flight");

    // Four stages hold at most four items
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd4)
        else $error("more items in flight than stages");

    // An empty pipeline always takes input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == 3'd0 |-> i_in_ready)
        else $error("empty pipeline refused input");

    // No result straight after reset
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown straight after reset");

endmodule

bind quad_downsample_nodata_core qd_chk u_qd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pixel (o_out.reduced_pixel),
    .i_out_last  (o_out.tile_done)
);
